[rtl/retry_backoff_scheduler_core_defines.svh]
// Assertion macros for the retry backoff scheduler.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef RETRY_BACKOFF_SCHEDULER_CORE_DEFINES_SVH
`define RETRY_BACKOFF_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication
`define RBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rbs_pkg.sv]
// Shared types and constants for the retry backoff scheduler.
// No dependencies; the modules and interfaces refer to this package by scoped names.
`timescale 1ns / 1ps

package rbs_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_RELEASE = 16;
    localparam int TIME_BITS   = 48;
    localparam int ALLOW_W     = 5;
    localparam int DELAY_W     = 17;
    localparam int QUEUE_DEPTH = 2;

    // floor(p/100) = (p * DIV100_K) >> DIV100_SHIFT, exact for p below 14e6
    localparam logic [23:0] DIV100_K     = 24'd10737419;
    localparam int          DIV100_SHIFT = 30;

    localparam logic       OP_OUTCOME = 1'b0;
    localparam logic       OP_RELEASE = 1'b1;

    localparam logic [1:0] OUTC_HTTP    = 2'd0;
    localparam logic [1:0] OUTC_NETERR  = 2'd1;
    localparam logic [1:0] OUTC_TIMEOUT = 2'd2;

    localparam logic [2:0] RES_SUCCESS   = 3'd0;
    localparam logic [2:0] RES_FAILURE   = 3'd1;
    localparam logic [2:0] RES_SCHEDULED = 3'd2;
    localparam logic [2:0] RES_RELEASED  = 3'd3;
    localparam logic [2:0] RES_DROPPED   = 3'd4;

    localparam logic [1:0] CMD_RESULT  = 2'd0;
    localparam logic [1:0] CMD_RETRY   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam int         CFG_IDX_W          = 4;
    localparam int         CFG_DATA_W         = 16;
    localparam logic [3:0] CFG_RETRY_LIMIT    = 4'd0;
    localparam logic [3:0] CFG_BASE_DELAY     = 4'd1;
    localparam logic [3:0] CFG_MAX_DELAY      = 4'd2;
    localparam logic [3:0] CFG_JITTER_PERCENT = 4'd3;
    localparam logic [3:0] CFG_TIMEOUT_EN     = 4'd4;
    localparam logic [3:0] CFG_NETERR_EN      = 4'd5;
    localparam logic [3:0] CFG_5XX_EN         = 4'd6;
    localparam logic [3:0] CFG_429_EN         = 4'd7;

    typedef struct packed {
        logic [7:0]  retry_limit;
        logic [15:0] base_delay;
        logic [15:0] max_delay;
        logic [6:0]  jitter_percent;
        logic        retry_timeout_en;
        logic        retry_neterr_en;
        logic        retry_5xx_en;
        logic        retry_429_en;
    } cfg_t;

    // Command passed from the front to the back through the queue
    typedef struct packed {
        logic [1:0]           cmd;
        logic [2:0]           kind;
        logic [15:0]          id;
        logic [8:0]           att;
        logic [8:0]           ovr;
        logic [DELAY_W-1:0]   delay;
        logic [TIME_BITS-1:0] due;
        logic [9:0]           status;
        logic [ALLOW_W-1:0]   allow;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

[rtl/rbs_channels.sv]
// Handshake channel interfaces: outcome/release items, result items, config writes.
// Depends on rbs_pkg for the time width and config port widths.
`timescale 1ns / 1ps

interface rbs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [15:0]                   request_id;
    logic [1:0]                    outcome_kind;
    logic [9:0]                    resp_status;
    logic [7:0]                    attempts_done;
    logic signed [8:0]             retry_override;
    logic [30:0]                   jitter_random;
    logic [rbs_pkg::TIME_BITS-1:0] current_time;
    logic [4:0]                    release_allow;

    modport source (output valid, op, request_id, outcome_kind, resp_status, attempts_done,
                    retry_override, jitter_random, current_time, release_allow,
                    input ready);
    modport sink (input valid, op, request_id, outcome_kind, resp_status, attempts_done,
                  retry_override, jitter_random, current_time, release_allow,
                  output ready);
endinterface

interface rbs_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    result_kind;
    logic [15:0]                   out_id;
    logic [8:0]                    attempt_count;
    logic signed [8:0]             out_override;
    logic [16:0]                   delay_value;
    logic [rbs_pkg::TIME_BITS-1:0] due_time;
    logic [9:0]                    out_status;
    logic                          last;

    modport source (output valid, result_kind, out_id, attempt_count, out_override,
                    delay_value, due_time, out_status, last, input ready);
    modport sink (input valid, result_kind, out_id, attempt_count, out_override,
                  delay_value, due_time, out_status, last, output ready);
endinterface

interface rbs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rbs_pkg::CFG_IDX_W-1:0]  index;
    logic [rbs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/rbs_front.sv]
// Front end: accepts items, classifies outcomes, computes backoff delay and due time.
// Depends on rbs_pkg and rbs_channels; feeds commands into the queue.
`timescale 1ns / 1ps

module rbs_front (
    input  logic                clk,
    input  logic                rst_n,
    rbs_in_if.sink              outcome,
    input  rbs_pkg::cfg_t       cfg,
    input  rbs_pkg::fifo_stat_t qstat,
    output logic                push,
    output rbs_pkg::cmd_t       push_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_BACKOFF = 3'd1;
    localparam logic [2:0] S_MUL     = 3'd2;
    localparam logic [2:0] S_DIV     = 3'd3;
    localparam logic [2:0] S_MOD     = 3'd4;
    localparam logic [2:0] S_JIT     = 3'd5;
    localparam logic [2:0] S_DUE     = 3'd6;
    localparam logic [2:0] S_PUSH    = 3'd7;

    localparam int TB = rbs_pkg::TIME_BITS;
    localparam int DW = rbs_pkg::DELAY_W;

    logic [2:0]          state_reg, state_next;
    rbs_pkg::cmd_t       cmd_reg, cmd_next;
    logic [15:0]         d_reg, d_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic [30:0]         rnd_reg, rnd_next;
    logic [22:0]         prod_reg, prod_next;
    logic [15:0]         delta_reg, delta_next;
    logic [16:0]         span_reg, span_next;
    logic [16:0]         rem_reg, rem_next;
    logic [4:0]          bit_reg, bit_next;
    logic [DW-1:0]       delay_reg, delay_next;

    logic [7:0]          retry_cap;
    logic                below;
    logic                is_ok;
    logic                want_retry;
    logic [9:0]          fail_status;
    logic [16:0]         dbl;
    logic [6:0]          jp;
    logic [46:0]         quo;
    logic [17:0]         shifted;
    logic [17:0]         jsum;
    logic [TB:0]         tot;
    logic [rbs_pkg::ALLOW_W-1:0] allow_c;

    assign outcome.ready = (state_reg == S_IDLE);
    assign push          = (state_reg == S_PUSH) && !qstat.full;
    assign push_data     = cmd_reg;

    // Classification of the incoming outcome
    always_comb
    begin
        retry_cap   = outcome.retry_override[8] ? cfg.retry_limit
                                                : outcome.retry_override[7:0];
        below       = outcome.attempts_done < retry_cap;
        is_ok       = (outcome.outcome_kind == rbs_pkg::OUTC_HTTP)
                      && (outcome.resp_status >= 10'd200) && (outcome.resp_status <= 10'd299);
        fail_status = 10'd0;
        want_retry  = 1'b0;
        case (outcome.outcome_kind)
            rbs_pkg::OUTC_HTTP:
            begin
                fail_status = outcome.resp_status;
                want_retry  = below
                    && ((cfg.retry_5xx_en && outcome.resp_status >= 10'd500
                         && outcome.resp_status <= 10'd599)
                        || (cfg.retry_429_en && outcome.resp_status == 10'd429));
            end
            rbs_pkg::OUTC_NETERR:  want_retry = below && cfg.retry_neterr_en;
            rbs_pkg::OUTC_TIMEOUT: want_retry = below && cfg.retry_timeout_en;
            default:               want_retry = 1'b0;
        endcase
        allow_c = (outcome.release_allow > rbs_pkg::ALLOW_W'(rbs_pkg::MAX_RELEASE))
                  ? rbs_pkg::ALLOW_W'(rbs_pkg::MAX_RELEASE) : outcome.release_allow;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        d_next     = d_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        prod_next  = prod_reg;
        delta_next = delta_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        delay_next = delay_reg;

        dbl     = {d_reg, 1'b0};
        jp      = (cfg.jitter_percent > 7'd100) ? 7'd100 : cfg.jitter_percent;
        quo     = {24'd0, prod_reg} * {23'd0, rbs_pkg::DIV100_K};
        shifted = {rem_reg, rnd_reg[bit_reg]};
        jsum    = {2'b00, d_reg} + {1'b0, rem_reg};
        tot     = {1'b0, cmd_reg.due} + (TB + 1)'(delay_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (outcome.valid)
                begin
                    cmd_next.id     = outcome.request_id;
                    cmd_next.att    = {1'b0, outcome.attempts_done} + 9'd1;
                    cmd_next.ovr    = 9'd0;
                    cmd_next.delay  = '0;
                    cmd_next.due    = '0;
                    cmd_next.status = 10'd0;
                    cmd_next.allow  = allow_c;
                    cmd_next.kind   = rbs_pkg::RES_FAILURE;
                    if (outcome.op == rbs_pkg::OP_RELEASE)
                    begin
                        cmd_next.cmd = rbs_pkg::CMD_RELEASE;
                        cmd_next.due = outcome.current_time;
                        state_next   = S_PUSH;
                    end
                    else if (is_ok)
                    begin
                        cmd_next.cmd    = rbs_pkg::CMD_RESULT;
                        cmd_next.kind   = rbs_pkg::RES_SUCCESS;
                        cmd_next.status = outcome.resp_status;
                        state_next      = S_PUSH;
                    end
                    else if (!want_retry)
                    begin
                        cmd_next.cmd    = rbs_pkg::CMD_RESULT;
                        cmd_next.status = fail_status;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        cmd_next.cmd = rbs_pkg::CMD_RETRY;
                        cmd_next.ovr = outcome.retry_override;
                        cmd_next.due = outcome.current_time;
                        d_next       = cfg.base_delay;
                        cnt_next     = outcome.attempts_done;
                        rnd_next     = outcome.jitter_random;
                        state_next   = S_BACKOFF;
                    end
                end
            end
            S_BACKOFF:
            begin
                // one doubling per cycle; stop at the cap, or when the count or the delay reaches zero
                if (cnt_reg == 8'd0 || d_reg == 16'd0)
                begin
                    state_next = S_MUL;
                end
                else if (dbl > {1'b0, cfg.max_delay})
                begin
                    d_next     = cfg.max_delay;
                    state_next = S_MUL;
                end
                else
                begin
                    d_next   = dbl[15:0];
                    cnt_next = cnt_reg - 8'd1;
                end
            end
            S_MUL:
            begin
                if (jp == 7'd0)
                begin
                    delay_next = {1'b0, d_reg};
                    state_next = S_DUE;
                end
                else
                begin
                    prod_next  = {7'd0, d_reg} * {16'd0, jp};
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                delta_next = quo[rbs_pkg::DIV100_SHIFT +: 16];
                span_next  = {quo[rbs_pkg::DIV100_SHIFT +: 16], 1'b1};
                rem_next   = 17'd0;
                bit_next   = 5'd30;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                // restoring remainder, one bit of the random value per cycle
                if (shifted >= {1'b0, span_reg})
                    rem_next = 17'(shifted - {1'b0, span_reg});
                else
                    rem_next = shifted[16:0];
                if (bit_reg == 5'd0)
                    state_next = S_JIT;
                else
                    bit_next = bit_reg - 5'd1;
            end
            S_JIT:
            begin
                if (jsum >= {2'b00, delta_reg})
                    delay_next = DW'(jsum - {2'b00, delta_reg});
                else
                    delay_next = '0;
                state_next = S_DUE;
            end
            S_DUE:
            begin
                cmd_next.delay = delay_reg;
                cmd_next.due   = tot[TB] ? {TB{1'b1}} : tot[TB-1:0];
                state_next     = S_PUSH;
            end
            S_PUSH:
            begin
                if (!qstat.full)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        d_reg     <= d_next;
        cnt_reg   <= cnt_next;
        rnd_reg   <= rnd_next;
        prod_reg  <= prod_next;
        delta_reg <= delta_next;
        span_reg  <= span_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        delay_reg <= delay_next;
    end

endmodule

[rtl/rbs_cmd_fifo.sv]
// Short command queue between the front and the back.
// Depends on rbs_pkg for the command type and depth.
`timescale 1ns / 1ps

module rbs_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rbs_pkg::cmd_t       push_data,
    input  logic                pop,
    output rbs_pkg::cmd_t       pop_data,
    output rbs_pkg::fifo_stat_t stat
);

    localparam int PW = $clog2(rbs_pkg::QUEUE_DEPTH);
    localparam int FW = $clog2(rbs_pkg::QUEUE_DEPTH + 1);

    rbs_pkg::cmd_t   mem_reg [rbs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]   fill_reg, fill_next;

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == FW'(rbs_pkg::QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(rbs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(rbs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/rbs_back.sv]
// Back end: sorted retry table, insert and release, and the result output register.
// Depends on rbs_pkg and rbs_channels; takes commands from the queue.
`timescale 1ns / 1ps

module rbs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rbs_pkg::cmd_t       pop_data,
    input  rbs_pkg::fifo_stat_t qstat,
    output logic                pop,
    rbs_out_if.source           result
);

    localparam int TB = rbs_pkg::TIME_BITS;
    localparam int DEPTH = rbs_pkg::TABLE_DEPTH;
    localparam int CW = rbs_pkg::CNT_W;
    localparam int AW = rbs_pkg::ALLOW_W;

    localparam logic B_IDLE = 1'b0;
    localparam logic B_REL  = 1'b1;

    typedef struct packed {
        logic [15:0]   id;
        logic [8:0]    att;
        logic [8:0]    ovr;
        logic [TB-1:0] due;
    } entry_t;

    entry_t              tab_reg [DEPTH];
    logic [CW-1:0]       cnt_reg;
    logic                state_reg;
    logic [TB-1:0]       rel_now_reg;
    logic [AW-1:0]       rel_allow_reg;
    logic [AW-1:0]       taken_reg;

    logic                rvalid_reg;
    logic [2:0]          rkind_reg;
    logic [15:0]         rid_reg;
    logic [8:0]          ratt_reg;
    logic [8:0]          rovr_reg;
    logic [16:0]         rdelay_reg;
    logic [TB-1:0]       rdue_reg;
    logic [9:0]          rstatus_reg;
    logic                rlast_reg;

    logic                out_free;
    logic                tab_full;
    logic                do_insert;
    logic                do_release;
    logic                can_release;
    logic                more_after;
    logic [DEPTH-1:0]    gt;
    logic [DEPTH-1:0]    gt_prev;
    entry_t              new_entry;

    assign out_free  = !rvalid_reg || result.ready;
    assign tab_full  = (cnt_reg == CW'(DEPTH));
    assign pop       = (state_reg == B_IDLE) && !qstat.empty && out_free;
    assign do_insert = pop && (pop_data.cmd == rbs_pkg::CMD_RETRY) && !tab_full;

    assign can_release = (cnt_reg != '0) && (tab_reg[0].due <= rel_now_reg)
                         && (taken_reg < rel_allow_reg);
    assign do_release  = (state_reg == B_REL) && can_release && out_free;
    assign more_after  = (cnt_reg > CW'(1)) && (tab_reg[1].due <= rel_now_reg)
                         && ((taken_reg + 1'b1) < rel_allow_reg);

    assign new_entry.id  = pop_data.id;
    assign new_entry.att = pop_data.att;
    assign new_entry.ovr = pop_data.ovr;
    assign new_entry.due = pop_data.due;

    // Entries strictly later than the new one move up; equal due times stay ahead
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
            gt[j] = (CW'(j) < cnt_reg) && (tab_reg[j].due > pop_data.due);
        gt_prev = {gt[DEPTH-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                if (gt_prev[j])
                    tab_reg[j] <= tab_reg[(j + DEPTH - 1) % DEPTH];
                else if (gt[j] || CW'(j) == cnt_reg)
                    tab_reg[j] <= new_entry;
            end
        end
        else if (do_release)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
                tab_reg[j] <= tab_reg[j + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            state_reg  <= B_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (do_insert)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_release)
                cnt_reg <= cnt_reg - 1'b1;

            if (pop && pop_data.cmd == rbs_pkg::CMD_RELEASE)
                state_reg <= B_REL;
            else if (state_reg == B_REL && !can_release)
                state_reg <= B_IDLE;

            if (pop && pop_data.cmd != rbs_pkg::CMD_RELEASE)
                rvalid_reg <= 1'b1;
            else if (do_release)
                rvalid_reg <= 1'b1;
            else if (result.ready)
                rvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rel_now_reg   <= pop_data.due;
            rel_allow_reg <= pop_data.allow;
            taken_reg     <= '0;
            rid_reg       <= pop_data.id;
            ratt_reg      <= pop_data.att;
            rlast_reg     <= 1'b1;
            case (pop_data.cmd)
                rbs_pkg::CMD_RETRY:
                begin
                    rkind_reg   <= tab_full ? rbs_pkg::RES_DROPPED : rbs_pkg::RES_SCHEDULED;
                    rovr_reg    <= pop_data.ovr;
                    rdelay_reg  <= pop_data.delay;
                    rdue_reg    <= pop_data.due;
                    rstatus_reg <= 10'd0;
                end
                default:
                begin
                    rkind_reg   <= pop_data.kind;
                    rovr_reg    <= 9'd0;
                    rdelay_reg  <= '0;
                    rdue_reg    <= '0;
                    rstatus_reg <= pop_data.status;
                end
            endcase
        end
        else if (do_release)
        begin
            taken_reg   <= taken_reg + 1'b1;
            rkind_reg   <= rbs_pkg::RES_RELEASED;
            rid_reg     <= tab_reg[0].id;
            ratt_reg    <= tab_reg[0].att;
            rovr_reg    <= tab_reg[0].ovr;
            rdelay_reg  <= '0;
            rdue_reg    <= tab_reg[0].due;
            rstatus_reg <= 10'd0;
            rlast_reg   <= !more_after;
        end
    end

    assign result.valid         = rvalid_reg;
    assign result.result_kind   = rkind_reg;
    assign result.out_id        = rid_reg;
    assign result.attempt_count = ratt_reg;
    assign result.out_override  = rovr_reg;
    assign result.delay_value   = rdelay_reg;
    assign result.due_time      = rdue_reg;
    assign result.out_status    = rstatus_reg;
    assign result.last          = rlast_reg;

endmodule

[rtl/retry_backoff_scheduler_core.sv]
// Top level of the retry backoff scheduler: config registers, front, queue, back.
// Depends on rbs_pkg, rbs_channels, rbs_front, rbs_cmd_fifo, rbs_back and the defines header.
//
// Channel   Modport  Moves
// outcome   sink     outcome or release item in
// result    source   result item out, last marks the final one of an item
// cfg       sink     register write, index and data
//
// An outcome that is not retried goes straight to the queue; a retry first runs the
// doubling loop (up to 16 steps) and, if the jitter percent is not zero, the 31-step
// jitter remainder. The input is ready again once the command is pushed to the queue.
// A release gives one result per cycle from the sorted table head while results are taken.
// Reset clears the config to defaults, the queue and the entry count; no clearing pass.
// The front and back stall independently; the result register frees the back on each take.
`timescale 1ns / 1ps
`include "retry_backoff_scheduler_core_defines.svh"

module retry_backoff_scheduler_core (
    input  logic      clk,
    input  logic      rst_n,
    rbs_in_if.sink    outcome,
    rbs_out_if.source result,
    rbs_cfg_if.sink   cfg
);

    rbs_pkg::cfg_t       cfg_reg;
    logic                q_push;
    logic                q_pop;
    rbs_pkg::cmd_t       q_wdata;
    rbs_pkg::cmd_t       q_rdata;
    rbs_pkg::fifo_stat_t q_stat;
    logic                res_single;

    assign cfg.ready  = 1'b1;
    assign res_single = result.valid && (result.result_kind != rbs_pkg::RES_RELEASED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit      <= 8'd2;
            cfg_reg.base_delay       <= 16'd300;
            cfg_reg.max_delay        <= 16'd5000;
            cfg_reg.jitter_percent   <= 7'd20;
            cfg_reg.retry_timeout_en <= 1'b1;
            cfg_reg.retry_neterr_en  <= 1'b1;
            cfg_reg.retry_5xx_en     <= 1'b1;
            cfg_reg.retry_429_en     <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rbs_pkg::CFG_RETRY_LIMIT:    cfg_reg.retry_limit      <= cfg.data[7:0];
                rbs_pkg::CFG_BASE_DELAY:     cfg_reg.base_delay       <= cfg.data;
                rbs_pkg::CFG_MAX_DELAY:      cfg_reg.max_delay        <= cfg.data;
                rbs_pkg::CFG_JITTER_PERCENT: cfg_reg.jitter_percent   <= cfg.data[6:0];
                rbs_pkg::CFG_TIMEOUT_EN:     cfg_reg.retry_timeout_en <= cfg.data[0];
                rbs_pkg::CFG_NETERR_EN:      cfg_reg.retry_neterr_en  <= cfg.data[0];
                rbs_pkg::CFG_5XX_EN:         cfg_reg.retry_5xx_en     <= cfg.data[0];
                rbs_pkg::CFG_429_EN:         cfg_reg.retry_429_en     <= cfg.data[0];
                default: ;
            endcase
        end
    end

    rbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .outcome   (outcome),
        .cfg       (cfg_reg),
        .qstat     (q_stat),
        .push      (q_push),
        .push_data (q_wdata)
    );

    rbs_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    rbs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (q_rdata),
        .qstat    (q_stat),
        .pop      (q_pop),
        .result   (result)
    );

    `RBS_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "command pushed into full queue")
    `RBS_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty, "command popped from empty queue")
    `RBS_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_stat.empty, "pushed command lost")
    `RBS_ASSERT_NOW(a_single_last, res_single, result.last, "outcome result without last")

endmodule
